// File: hdl/uvrn_pkg.sv
// ----------------------------------------------------------------------------
// uvrn_pkg
// Shared constants for the vector rotate and renormalize pipeline.
// ----------------------------------------------------------------------------
package uvrn_pkg;

    localparam int VECTOR_WIDTH_DEF = 32;
    localparam int COEFF_WIDTH_DEF  = 18;

    localparam int NUM_ROWS  = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2
    } t_cfg_idx;

endpackage

// File: hdl/uvrn_div.sv
// ----------------------------------------------------------------------------
// uvrn_div
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor((mag * 2^(VW-1) + len) / (2 * len)) and carries the sign
// and the low magnitude bits alongside.
// ----------------------------------------------------------------------------
module uvrn_div #(
    parameter int VW = 32,
    parameter int MW = 36,
    parameter int LW = 37
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [MW-1:0] i_mag,
    input  logic          i_neg,
    input  logic [LW-1:0] i_len,
    output logic [VW-1:0] o_quot,
    output logic [VW-1:0] o_mag_low,
    output logic          o_neg
);

    localparam int NW = MW + VW;

    logic [NW-1:0] w_num;

    logic [LW:0]   r_rem  [0:VW];
    logic [LW:0]   r_den  [0:VW];
    logic [VW-1:0] r_nlo  [0:VW];
    logic [VW-1:0] r_quot [0:VW];
    logic [VW-1:0] r_pass [0:VW];
    logic          r_neg  [0:VW];

    logic [LW:0]   n_rem  [1:VW];
    logic [VW-1:0] n_nlo  [1:VW];
    logic [VW-1:0] n_quot [1:VW];

    assign w_num = (NW'(i_mag) << (VW - 1)) + NW'(i_len);

    always_comb begin
        logic [LW+1:0] rem_sh;
        for (int k = 0; k < VW; k++) begin
            rem_sh = {r_rem[k], r_nlo[k][VW-1]};
            n_nlo[k+1] = {r_nlo[k][VW-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_den[k]}) begin
                n_rem[k+1]  = (LW+1)'(rem_sh - {1'b0, r_den[k]});
                n_quot[k+1] = {r_quot[k][VW-2:0], 1'b1};
            end else begin
                n_rem[k+1]  = rem_sh[LW:0];
                n_quot[k+1] = {r_quot[k][VW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= (LW+1)'(w_num[NW-1:VW]);
            r_den[0]  <= {i_len, 1'b0};
            r_nlo[0]  <= w_num[VW-1:0];
            r_quot[0] <= '0;
            r_pass[0] <= i_mag[VW-1:0];
            r_neg[0]  <= i_neg;
            for (int k = 1; k <= VW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= r_den[k-1];
                r_nlo[k]  <= n_nlo[k];
                r_quot[k] <= n_quot[k];
                r_pass[k] <= r_pass[k-1];
                r_neg[k]  <= r_neg[k-1];
            end
        end
    end

    assign o_quot    = r_quot[VW];
    assign o_mag_low = r_pass[VW];
    assign o_neg     = r_neg[VW];

endmodule

// File: hdl/unit_vector_rotate_normalize.sv
// ----------------------------------------------------------------------------
// unit_vector_rotate_normalize
// Rotates a vector by a 3x3 matrix and rescales it to unit length, unless its length is zero or already one.
//
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tdata: x, y, z
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tdata: x, y, z; tuser: renorm
// cfg       in   i_cfg_we                          i_cfg_idx, i_cfg_data
//
// one word per cycle while the output register is not stalled; the square root
// and the divider each resolve one result bit per stage
// the whole pipeline holds while the output register is full and not taken
// i_rst_n clears the valid bits and loads the identity matrix
// ----------------------------------------------------------------------------
module unit_vector_rotate_normalize #(
    parameter int VECTOR_WIDTH = uvrn_pkg::VECTOR_WIDTH_DEF,
    parameter int COEFF_WIDTH  = uvrn_pkg::COEFF_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // vertex_x, vertex_y, vertex_z
    input  logic [((3*VECTOR_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [((3*VECTOR_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,
    // renormalized
    output logic                                    o_m_axis_tuser,
    input  logic                                    i_cfg_we,
    input  logic [uvrn_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [3*COEFF_WIDTH-1:0]                i_cfg_data
);

    import uvrn_pkg::*;

    localparam int VW   = VECTOR_WIDTH;
    localparam int CW   = COEFF_WIDTH;
    localparam int CF   = CW - 2;
    localparam int PW   = VW + CW;
    localparam int SUMW = PW + 2;
    localparam int MW   = VW + 4;
    localparam int H    = (MW + 1) / 2;
    localparam int HW   = MW - H;
    localparam int SQW  = 2 * MW;
    localparam int SW   = 2 * MW + 2;
    localparam int LW   = MW + 1;
    localparam int DW   = ((3 * VW + 7) / 8) * 8;
    localparam logic [SW-1:0] S_ONE = SW'(1) << (2 * (VW - 2));
    localparam logic signed [VW:0] V_ONE = (VW+1)'(1) << (VW - 2);

    logic w_en;

    // configuration
    logic [3*CW-1:0] r_row [0:NUM_ROWS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= (3*CW)'(1) << CF;
            r_row[1] <= (3*CW)'(1) << (CF + CW);
            r_row[2] <= (3*CW)'(1) << (CF + 2 * CW);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_ROW0: r_row[0] <= i_cfg_data;
                REG_ROW1: r_row[1] <= i_cfg_data;
                REG_ROW2: r_row[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage registers
    logic                 r_vld [1:5];
    logic signed [PW-1:0] r_p   [0:2][0:2];
    logic [MW-1:0]        r_r   [0:2];
    logic [MW-1:0]        r_mag3 [0:2];
    logic [MW-1:0]        r_mag4 [0:2];
    logic [MW-1:0]        r_mag5 [0:2];
    logic                 r_neg3 [0:2];
    logic                 r_neg4 [0:2];
    logic                 r_neg5 [0:2];
    logic [2*HW-1:0]      r_hh  [0:2];
    logic [HW+H-1:0]      r_hl  [0:2];
    logic [2*H-1:0]       r_ll  [0:2];
    logic [SQW-1:0]       r_sq  [0:2];

    logic signed [PW-1:0] n_p   [0:2][0:2];
    logic [MW-1:0]        n_r   [0:2];
    logic [SW-1:0]        n_s;

    always_comb begin
        logic signed [PW-1:0]   ce;
        logic signed [PW-1:0]   ve;
        logic signed [SUMW-1:0] sum;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ce = {{(PW-CW){r_row[i][j*CW+CW-1]}}, r_row[i][j*CW +: CW]};
                ve = {{(PW-VW){i_s_axis_tdata[j*VW+VW-1]}}, i_s_axis_tdata[j*VW +: VW]};
                n_p[i][j] = ce * ve;
            end
            sum = SUMW'(r_p[i][0]) + SUMW'(r_p[i][1]) + SUMW'(r_p[i][2])
                + (SUMW'(1) << (CF - 1));
            n_r[i] = sum[SUMW-1:CF];
        end
        n_s = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    // square root, one result bit per stage
    logic [LW+1:0] r_sq_rem  [0:LW];
    logic [LW-1:0] r_sq_root [0:LW];
    logic [SW-1:0] r_sq_rad  [0:LW];
    logic [MW-1:0] r_sq_mag  [0:LW][0:2];
    logic          r_sq_neg  [0:LW][0:2];
    logic          r_sq_flag [0:LW];
    logic          r_sq_vld  [0:LW];

    logic [LW+1:0] n_sq_rem  [1:LW];
    logic [LW-1:0] n_sq_root [1:LW];

    always_comb begin
        logic [LW+1:0] rem_sh;
        logic [LW+1:0] trial;
        for (int k = 0; k < LW; k++) begin
            rem_sh = {r_sq_rem[k][LW-1:0], r_sq_rad[k][SW-1:SW-2]};
            trial  = {r_sq_root[k], 2'b01};
            if (rem_sh >= trial) begin
                n_sq_rem[k+1]  = rem_sh - trial;
                n_sq_root[k+1] = {r_sq_root[k][LW-2:0], 1'b1};
            end else begin
                n_sq_rem[k+1]  = rem_sh;
                n_sq_root[k+1] = {r_sq_root[k][LW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= n_p[i][j];
                end
                r_r[i]    <= n_r[i];
                r_neg3[i] <= r_r[i][MW-1];
                r_mag3[i] <= r_r[i][MW-1] ? (~r_r[i] + MW'(1)) : r_r[i];
                r_hh[i]   <= (2*HW)'(r_mag3[i][MW-1:H]) * (2*HW)'(r_mag3[i][MW-1:H]);
                r_hl[i]   <= (HW+H)'(r_mag3[i][MW-1:H]) * (HW+H)'(r_mag3[i][H-1:0]);
                r_ll[i]   <= (2*H)'(r_mag3[i][H-1:0]) * (2*H)'(r_mag3[i][H-1:0]);
                r_mag4[i] <= r_mag3[i];
                r_neg4[i] <= r_neg3[i];
                r_sq[i]   <= (SQW'(r_hh[i]) << (2 * H)) + (SQW'(r_hl[i]) << (H + 1))
                           + SQW'(r_ll[i]);
                r_mag5[i] <= r_mag4[i];
                r_neg5[i] <= r_neg4[i];
                r_sq_mag[0][i] <= r_mag5[i];
                r_sq_neg[0][i] <= r_neg5[i];
            end
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= n_s;
            r_sq_flag[0] <= (n_s != '0) && (n_s != S_ONE);
            for (int k = 1; k <= LW; k++) begin
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_rad[k]  <= r_sq_rad[k-1] << 2;
                r_sq_flag[k] <= r_sq_flag[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_sq_mag[k][i] <= r_sq_mag[k-1][i];
                    r_sq_neg[k][i] <= r_sq_neg[k-1][i];
                end
            end
        end
    end

    // dividers, one lane per component
    logic [VW-1:0] w_quot [0:2];
    logic [VW-1:0] w_mlow [0:2];
    logic          w_neg  [0:2];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        uvrn_div #(
            .VW (VW),
            .MW (MW),
            .LW (LW)
        ) u_div (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_mag     (r_sq_mag[LW][g]),
            .i_neg     (r_sq_neg[LW][g]),
            .i_len     (r_sq_root[LW]),
            .o_quot    (w_quot[g]),
            .o_mag_low (w_mlow[g]),
            .o_neg     (w_neg[g])
        );
    end

    logic r_dv_vld  [0:VW];
    logic r_dv_flag [0:VW];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 5; k++) begin
                r_vld[k] <= 1'b0;
            end
            for (int k = 0; k <= LW; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
            for (int k = 0; k <= VW; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= 5; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_sq_vld[0] <= r_vld[5];
            for (int k = 1; k <= LW; k++) begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
            r_dv_vld[0] <= r_sq_vld[LW];
            for (int k = 1; k <= VW; k++) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_flag[0] <= r_sq_flag[LW];
            for (int k = 1; k <= VW; k++) begin
                r_dv_flag[k] <= r_dv_flag[k-1];
            end
        end
    end

    // output register
    logic          r_out_vld;
    logic          r_out_flag;
    logic [VW-1:0] r_out [0:2];
    logic [VW-1:0] n_out [0:2];

    always_comb begin
        logic [VW-1:0] val;
        for (int i = 0; i < 3; i++) begin
            val = r_dv_flag[VW] ? w_quot[i] : w_mlow[i];
            n_out[i] = w_neg[i] ? (~val + VW'(1)) : val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[VW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_flag <= r_dv_flag[VW];
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= n_out[i];
            end
        end
    end

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_flag;
    assign o_m_axis_tdata  = DW'({r_out[2], r_out[1], r_out[0]});

    // checks
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[1])
        else $error("accepted word did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_sq_flag[LW]) && $stable(r_sq_root[LW])))
        else $error("pipeline moved during a stall");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_flag) |->
        ($signed({r_out[0][VW-1], r_out[0]}) <= V_ONE
         && $signed({r_out[0][VW-1], r_out[0]}) >= -V_ONE
         && $signed({r_out[1][VW-1], r_out[1]}) <= V_ONE
         && $signed({r_out[1][VW-1], r_out[1]}) >= -V_ONE
         && $signed({r_out[2][VW-1], r_out[2]}) <= V_ONE
         && $signed({r_out[2][VW-1], r_out[2]}) >= -V_ONE))
        else $error("renormalized word outside unit range");

endmodule

// File: dv/tb_unit_vector_rotate_normalize.sv
// ----------------------------------------------------------------------------
// tb_unit_vector_rotate_normalize
// Streams vertices through the rotate and renormalize pipeline under several
// matrices, predicts each rotated word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_unit_vector_rotate_normalize;

    timeunit 1ns;
    timeprecision 1ps;

    import uvrn_pkg::*;

    localparam int VW    = 32;
    localparam int CW    = 18;
    localparam int VF    = VW - 2;
    localparam int CF    = CW - 2;
    localparam int DW    = ((3*VW+7)/8)*8;
    localparam int LAT   = 77;

    typedef struct packed {
        logic [VW-1:0] x;
        logic [VW-1:0] y;
        logic [VW-1:0] z;
        logic          renorm;
    } t_rot;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DW-1:0]     i_s_axis_tdata = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DW-1:0]     o_m_axis_tdata;
    logic              o_m_axis_tuser;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_ROW0;
    logic [3*CW-1:0]   i_cfg_data = '0;

    unit_vector_rotate_normalize u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [3*CW-1:0] mat_row [3];
    logic [DW-1:0]   vertex_q [$];
    t_rot            rot_exp_q [$];
    int              n_err = 0;
    int              n_rot = 0;
    int              n_renorm = 0;
    int              tx_gap = 0;
    int              rx_gap = 0;

    // exact rotation then, unless the squared length is zero or unit, length division, all in wide integers
    function automatic t_rot rotate_vertex(logic [DW-1:0] w);
        logic signed [VW-1:0]  v [3];
        logic signed [127:0]   acc;
        logic signed [127:0]   r [3];
        logic        [127:0]   mag [3];
        logic        [127:0]   s, len, q;
        logic signed [CW-1:0]  c;
        t_rot                  o;
        for (int j = 0; j < 3; j++) v[j] = w[j*VW +: VW];
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                c = mat_row[i][j*CW +: CW];
                acc += 128'(c) * 128'(v[j]);
            end
            r[i] = (acc + (128'sd1 <<< (CF-1))) >>> CF;
        end
        s = 0;
        for (int j = 0; j < 3; j++) begin
            mag[j] = r[j] < 0 ? -r[j] : r[j];
            s += mag[j] * mag[j];
        end
        if (s == 0 || s == (128'd1 << (2*VF))) begin
            o.x = r[0][VW-1:0];
            o.y = r[1][VW-1:0];
            o.z = r[2][VW-1:0];
            o.renorm = 1'b0;
        end else begin
            len = 0;
            for (int b = 63; b >= 0; b--)
                if ((len | (128'd1 << b)) * (len | (128'd1 << b)) <= s)
                    len |= 128'd1 << b;
            for (int j = 0; j < 3; j++) begin
                q = (((mag[j] << (VW-1)) + len) / (len << 1)) & {64{1'b1}};
                if (r[j] < 0) q = -q;
                if (j == 0) o.x = q[VW-1:0];
                if (j == 1) o.y = q[VW-1:0];
                if (j == 2) o.z = q[VW-1:0];
            end
            o.renorm = 1'b1;
        end
        return o;
    endfunction

    function automatic logic [VW-1:0] rand_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 32'sd1 << VF;
        if (k == 1) return -(32'sd1 << VF);
        if (k == 2) return $urandom();
        return $urandom_range(0, 32'h7fffffff) - 32'h40000000;
    endfunction

    function automatic logic [CW-1:0] rand_coef();
        int k;
        k = $urandom_range(0, 5);
        if (k == 0) return 18'sd1 << CF;
        if (k == 1) return -(18'sd1 << CF);
        if (k == 2) return '0;
        return CW'($urandom());
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                rot_exp_q.push_back(rotate_vertex(i_s_axis_tdata));
                void'(vertex_q.pop_front());
                tx_gap = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0) tx_gap = 0;
            end
            if (vertex_q.size() > 0 && (tx_gap == 0 || i_s_axis_tvalid && !o_s_axis_tready
                    || (i_s_axis_tvalid && o_s_axis_tready && tx_gap == 0))) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= vertex_q[0];
            end else begin
                i_s_axis_tvalid <= 1'b0;
                if (tx_gap > 0) tx_gap--;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rot got, want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.x = o_m_axis_tdata[0 +: VW];
                got.y = o_m_axis_tdata[VW +: VW];
                got.z = o_m_axis_tdata[2*VW +: VW];
                got.renorm = o_m_axis_tuser;
                if (rot_exp_q.size() == 0) begin
                    $error("unexpected word x=%h", got.x);
                    n_err++;
                end else begin
                    want = rot_exp_q.pop_front();
                    n_rot++;
                    if (want.renorm) n_renorm++;
                    if (got.x !== want.x) begin
                        $error("rotated_x exp %h got %h", want.x, got.x); n_err++;
                    end
                    if (got.y !== want.y) begin
                        $error("rotated_y exp %h got %h", want.y, got.y); n_err++;
                    end
                    if (got.z !== want.z) begin
                        $error("rotated_z exp %h got %h", want.z, got.z); n_err++;
                    end
                    if (got.renorm !== want.renorm) begin
                        $error("renormalized exp %b got %b", want.renorm, got.renorm);
                        n_err++;
                    end
                end
                rx_gap = $urandom_range(0, 5);
                if ($urandom_range(0, 3) == 0) rx_gap = 0;
            end
            if (rx_gap > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_gap--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [DW-1:0] pack_vertex(logic [VW-1:0] x, y, z);
        return {x, y, z} == 0 ? '0 : DW'({z, y, x});
    endfunction

    task automatic write_row(t_cfg_idx idx, logic [3*CW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        mat_row[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (vertex_q.size() == 0 && !i_s_axis_tvalid && rot_exp_q.size() == 0);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic run_vertices(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0)
                vertex_q.push_back(pack_vertex(32'sd1 << VF, 0, 0));
            else
                vertex_q.push_back(pack_vertex(rand_comp(), rand_comp(), rand_comp()));
        end
        drain();
    endtask

    localparam logic [CW-1:0] C_ONE  = 18'sd1 << CF;
    localparam logic [CW-1:0] C_NEG  = -(18'sd1 << CF);
    localparam logic [CW-1:0] C_MAX  = 18'h1ffff;
    localparam logic [CW-1:0] C_MIN  = 18'h20000;

    initial begin
        mat_row[0] = {18'd0, 18'd0, C_ONE};
        mat_row[1] = {18'd0, C_ONE, 18'd0};
        mat_row[2] = {C_ONE, 18'd0, 18'd0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // identity: exact unit, zero, extremes, non-unit lengths
        vertex_q.push_back(pack_vertex(32'sd1 << VF, 0, 0));
        vertex_q.push_back(pack_vertex(0, -(32'sd1 << VF), 0));
        vertex_q.push_back(pack_vertex(0, 0, 0));
        vertex_q.push_back(pack_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff));
        vertex_q.push_back(pack_vertex(32'h80000000, 32'h80000000, 32'h80000000));
        vertex_q.push_back(pack_vertex(32'hffffffff, 0, 0));
        vertex_q.push_back(pack_vertex(1, 1, 1));
        vertex_q.push_back(pack_vertex(32'h2d413ccd, 32'h2d413ccd, 0));
        vertex_q.push_back(pack_vertex(32'h20000000, 32'hc0000000, 32'h1fffffff));
        vertex_q.push_back(pack_vertex(-(32'sd1 << VF), -(32'sd1 << VF), 32'sd1 << VF));
        drain();
        // extreme coefficients
        write_row(REG_ROW0, {C_MIN, C_MAX, C_NEG});
        write_row(REG_ROW1, {C_MAX, C_MIN, C_MAX});
        write_row(REG_ROW2, {C_NEG, C_NEG, C_MIN});
        vertex_q.push_back(pack_vertex(32'sd1 << VF, 0, 0));
        vertex_q.push_back(pack_vertex(32'h80000000, 32'h7fffffff, 32'h80000000));
        vertex_q.push_back(pack_vertex(0, 0, 0));
        vertex_q.push_back(pack_vertex(0, 0, 32'hffffffff));
        drain();
        // zero matrix
        write_row(REG_ROW0, '0);
        write_row(REG_ROW1, '0);
        write_row(REG_ROW2, '0);
        run_vertices(20);
        // permutation with a sign flip, then random matrices
        write_row(REG_ROW0, {18'd0, C_ONE, 18'd0});
        write_row(REG_ROW1, {18'd0, 18'd0, C_NEG});
        write_row(REG_ROW2, {C_ONE, 18'd0, 18'd0});
        run_vertices(200);
        for (int p = 0; p < 5; p++) begin
            write_row(REG_ROW0, {rand_coef(), rand_coef(), rand_coef()});
            write_row(REG_ROW1, {rand_coef(), rand_coef(), rand_coef()});
            write_row(REG_ROW2, {rand_coef(), rand_coef(), rand_coef()});
            run_vertices(220);
        end
        $display("checked %0d rotated words, %0d renormalized, over %0d matrices",
                 n_rot, n_renorm, 9);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
